// ===== rtl/xmcrc_pkg.sv =====
// Shared types, protocol codes and the CRC-16/XMODEM byte update for the
// XMODEM-CRC receiver. No dependencies.
package xmcrc_pkg;

    localparam int SMALL_PACKET_BYTES = 128;
    localparam int LARGE_PACKET_BYTES = 1024;
    localparam int OFFSET_BITS_DEF    = 20;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int INDEX_W = 11;
    localparam int BASE_W  = 21;

    // Control characters
    localparam logic [7:0] CH_SOH   = 8'h01;
    localparam logic [7:0] CH_STX   = 8'h02;
    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] CH_ACK   = 8'h06;
    localparam logic [7:0] CH_NAK   = 8'h15;
    localparam logic [7:0] CH_CAN   = 8'h18;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_MAX_ERRORS  = 2'd0;
    localparam logic [1:0] REG_IMAGE_LIMIT = 2'd1;
    localparam logic [1:0] REG_IDLE_WINDOW = 2'd2;

    localparam logic [7:0]  MAX_ERRORS_RST  = 8'd3;
    localparam logic [20:0] IMAGE_LIMIT_RST = 21'd65536;
    localparam logic [7:0]  IDLE_WINDOW_RST = 8'd15;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_NUMBER = 3'd1,
        PH_COMPL  = 3'd2,
        PH_DATA   = 3'd3,
        PH_CRC_HI = 3'd4,
        PH_CRC_LO = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        SES_RUNNING  = 2'd0,
        SES_COMPLETE = 2'd1,
        SES_ABORTED  = 2'd2,
        SES_IDLE     = 2'd3
    } session_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_SEND   = 2'd1,
        KIND_WRITE  = 2'd2,
        KIND_ERASE  = 2'd3
    } kind_t;

    // One byte of CRC-16/XMODEM, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/xmodem_crc_receiver_top.sv =====
// XMODEM-CRC receiver: one received byte or timeout per input transaction,
// protocol state update and result register. The first result is registered
// in the cycle after input accept. Throughput one input per cycle while the
// output is taken; a cancel at the error limit sends two results and holds
// input until the first is taken. Reset (aresetn, synchronous, active low)
// restores the idle-armed state and the register defaults. Depends on xmcrc_pkg.
module xmodem_crc_receiver_top
    import xmcrc_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_action,
    input  logic [7:0]             s_rx_byte,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_kind,
    output logic [7:0]             m_tx_byte,
    output logic [7:0]             m_write_data,
    output logic [OFFSET_BITS-1:0] m_write_offset,
    output logic [1:0]             m_session,
    output logic                   m_last
);

    localparam int WIDE_W = (OFFSET_BITS > BASE_W + 1) ? OFFSET_BITS : BASE_W + 1;

    // Configuration registers
    logic [7:0]        max_errors_reg;
    logic [BASE_W-1:0] image_limit_reg;
    logic [7:0]        idle_window_reg;

    // Protocol state
    phase_t             phase_reg, phase_next;
    logic [INDEX_W-1:0] byte_index_reg, byte_index_next;
    logic               big_packet_reg, big_packet_next;
    logic [15:0]        crc_reg, crc_next;
    logic [7:0]         crc_high_reg, crc_high_next;
    logic [7:0]         rx_number_reg, rx_number_next;
    logic               header_fault_reg, header_fault_next;
    logic [7:0]         expected_reg, expected_next;
    logic [BASE_W-1:0]  image_base_reg, image_base_next;
    logic               image_erased_reg, image_erased_next;
    logic [7:0]         error_count_reg, error_count_next;
    logic [7:0]         idle_count_reg, idle_count_next;
    session_t           session_reg, session_next;

    // Result register
    logic                   out_valid_reg;
    logic                   out_double_reg;
    kind_t                  out_kind_reg;
    logic [7:0]             out_tx_reg;
    logic [7:0]             out_data_reg;
    logic [OFFSET_BITS-1:0] out_offset_reg;
    session_t               out_session_reg;

    kind_t                  res_kind;
    logic [7:0]             res_tx;
    logic [7:0]             res_data;
    logic [OFFSET_BITS-1:0] res_offset;
    logic                   res_double;

    logic in_accept;
    logic out_accept;
    logic cfg_write;

    // Shared decode
    logic               timeout;
    logic               running;
    logic               in_header;
    logic [INDEX_W-1:0] packet_size;
    logic [BASE_W:0]    base_plus_size;
    logic               fits;
    logic [INDEX_W-1:0] index_inc;
    logic               data_done;
    logic               is_space;
    logic               idle_expired;
    logic               err_limit;
    logic               want_c;
    logic               is_header;
    logic [WIDE_W-1:0]  write_sum;
    logic [WIDE_W-1:0]  base_wide;
    logic [8:0]         compl_sum;
    logic [15:0]        crc_update;
    logic [7:0]         error_inc;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    assign in_accept  = s_valid & s_ready;
    assign out_accept = m_valid & m_ready;
    assign s_ready    = !out_valid_reg || (m_ready && !out_double_reg);

    assign timeout        = s_action;
    assign running        = (session_reg == SES_RUNNING);
    assign in_header      = (phase_reg == PH_HEADER);
    assign packet_size    = big_packet_reg ? INDEX_W'(LARGE_PACKET_BYTES)
                                           : INDEX_W'(SMALL_PACKET_BYTES);
    assign base_plus_size = {1'b0, image_base_reg} + (BASE_W + 1)'(packet_size);
    assign fits           = base_plus_size <= {1'b0, image_limit_reg};
    assign index_inc      = byte_index_reg + INDEX_W'(1);
    assign data_done      = index_inc >= packet_size;
    assign is_space       = !timeout && (s_rx_byte == CH_SPACE);
    assign idle_expired   = idle_count_reg <= 8'd1;
    assign err_limit      = error_count_reg >= max_errors_reg;
    assign want_c         = timeout && !image_erased_reg;
    assign is_header      = !timeout && (s_rx_byte == CH_SOH || s_rx_byte == CH_STX);
    assign base_wide      = WIDE_W'(image_base_reg);
    assign write_sum      = base_wide + WIDE_W'(byte_index_reg);
    assign compl_sum      = {1'b0, rx_number_reg} + {1'b0, s_rx_byte};
    assign crc_update     = crc16_byte(crc_reg, s_rx_byte);
    assign error_inc      = (error_count_reg == 8'hff) ? error_count_reg
                                                       : error_count_reg + 8'd1;

    // Phase sequencing
    always_comb begin
        phase_next = phase_reg;
        if (running) begin
            if (!in_header) begin
                if (timeout) begin
                    phase_next = PH_HEADER;
                end else begin
                    unique case (phase_reg)
                        PH_NUMBER: phase_next = PH_COMPL;
                        PH_COMPL:  phase_next = PH_DATA;
                        PH_DATA:   phase_next = data_done ? PH_CRC_HI : PH_DATA;
                        PH_CRC_HI: phase_next = PH_CRC_LO;
                        default:   phase_next = PH_HEADER;
                    endcase
                end
            end else if (!is_space && !idle_expired && !err_limit && is_header) begin
                phase_next = PH_NUMBER;
            end
        end
    end

    // Results and datapath state
    always_comb begin
        res_kind          = KIND_STATUS;
        res_tx            = 8'h00;
        res_data          = 8'h00;
        res_offset        = '0;
        res_double        = 1'b0;
        byte_index_next   = byte_index_reg;
        big_packet_next   = big_packet_reg;
        crc_next          = crc_reg;
        crc_high_next     = crc_high_reg;
        rx_number_next    = rx_number_reg;
        header_fault_next = header_fault_reg;
        expected_next     = expected_reg;
        image_base_next   = image_base_reg;
        image_erased_next = image_erased_reg;
        error_count_next  = error_count_reg;
        idle_count_next   = idle_count_reg;
        session_next      = session_reg;

        if (running) begin
            if (!in_header) begin
                if (timeout) begin
                    res_kind         = KIND_SEND;
                    res_tx           = CH_NAK;
                    error_count_next = error_inc;
                end else begin
                    unique case (phase_reg)
                        PH_NUMBER: rx_number_next = s_rx_byte;
                        PH_COMPL: begin
                            if (rx_number_reg != expected_reg || compl_sum != 9'd255) begin
                                header_fault_next = 1'b1;
                            end
                        end
                        PH_DATA: begin
                            crc_next        = crc_update;
                            byte_index_next = index_inc;
                            if (fits) begin
                                res_kind   = KIND_WRITE;
                                res_data   = s_rx_byte;
                                res_offset = write_sum[OFFSET_BITS-1:0];
                            end
                        end
                        PH_CRC_HI: crc_high_next = s_rx_byte;
                        PH_CRC_LO: begin
                            res_kind = KIND_SEND;
                            if (!header_fault_reg && fits &&
                                {crc_high_reg, s_rx_byte} == crc_reg) begin
                                res_tx          = CH_ACK;
                                expected_next   = expected_reg + 8'd1;
                                image_base_next = base_plus_size[BASE_W-1:0];
                            end else begin
                                res_tx           = CH_NAK;
                                error_count_next = error_inc;
                            end
                        end
                        default: ;
                    endcase
                end
            end else if (is_space) begin
                res_kind        = KIND_SEND;
                res_tx          = CH_D;
                idle_count_next = idle_window_reg;
            end else if (idle_expired) begin
                idle_count_next = 8'd0;
                session_next    = SES_IDLE;
                if (want_c) begin
                    res_kind = KIND_SEND;
                    res_tx   = CH_C;
                end
            end else begin
                idle_count_next = idle_count_reg - 8'd1;
                if (err_limit) begin
                    // cancel is sent twice
                    res_kind     = KIND_SEND;
                    res_tx       = CH_CAN;
                    res_double   = 1'b1;
                    session_next = SES_ABORTED;
                end else if (want_c) begin
                    res_kind = KIND_SEND;
                    res_tx   = CH_C;
                end else if (!timeout) begin
                    if (is_header) begin
                        idle_count_next   = idle_window_reg;
                        big_packet_next   = (s_rx_byte == CH_STX);
                        byte_index_next   = '0;
                        crc_next          = 16'h0000;
                        header_fault_next = 1'b0;
                        if (!image_erased_reg) begin
                            res_kind          = KIND_ERASE;
                            res_offset        = base_wide[OFFSET_BITS-1:0];
                            image_erased_next = 1'b1;
                        end
                    end else if (s_rx_byte == CH_EOT) begin
                        res_kind     = KIND_SEND;
                        res_tx       = CH_ACK;
                        session_next = SES_COMPLETE;
                    end else if (s_rx_byte == CH_CAN) begin
                        session_next = SES_ABORTED;
                    end else begin
                        res_kind         = KIND_SEND;
                        res_tx           = CH_NAK;
                        error_count_next = error_inc;
                    end
                end
            end
        end
    end

    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_errors_reg  <= MAX_ERRORS_RST;
            image_limit_reg <= IMAGE_LIMIT_RST;
            idle_window_reg <= IDLE_WINDOW_RST;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_MAX_ERRORS:  max_errors_reg  <= pwdata[7:0];
                REG_IMAGE_LIMIT: image_limit_reg <= pwdata[BASE_W-1:0];
                REG_IDLE_WINDOW: idle_window_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MAX_ERRORS:  prdata = APB_DATA_W'(max_errors_reg);
            REG_IMAGE_LIMIT: prdata = APB_DATA_W'(image_limit_reg);
            REG_IDLE_WINDOW: prdata = APB_DATA_W'(idle_window_reg);
            default:         prdata = '0;
        endcase
    end

    // Protocol state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            byte_index_reg   <= '0;
            big_packet_reg   <= 1'b0;
            crc_reg          <= 16'h0000;
            crc_high_reg     <= 8'h00;
            rx_number_reg    <= 8'h00;
            header_fault_reg <= 1'b0;
            expected_reg     <= 8'd1;
            image_base_reg   <= '0;
            image_erased_reg <= 1'b0;
            error_count_reg  <= 8'd0;
            idle_count_reg   <= 8'd1;
            session_reg      <= SES_RUNNING;
        end else if (in_accept) begin
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            big_packet_reg   <= big_packet_next;
            crc_reg          <= crc_next;
            crc_high_reg     <= crc_high_next;
            rx_number_reg    <= rx_number_next;
            header_fault_reg <= header_fault_next;
            expected_reg     <= expected_next;
            image_base_reg   <= image_base_next;
            image_erased_reg <= image_erased_next;
            error_count_reg  <= error_count_next;
            idle_count_reg   <= idle_count_next;
            session_reg      <= session_next;
        end
    end

    // Result register: a double result repeats the same transaction once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            out_double_reg <= 1'b0;
        end else if (in_accept) begin
            out_valid_reg  <= 1'b1;
            out_double_reg <= res_double;
        end else if (out_accept) begin
            if (out_double_reg) begin
                out_double_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_kind_reg    <= res_kind;
            out_tx_reg      <= res_tx;
            out_data_reg    <= res_data;
            out_offset_reg  <= res_offset;
            out_session_reg <= session_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_kind_reg;
    assign m_tx_byte      = out_tx_reg;
    assign m_write_data   = out_data_reg;
    assign m_write_offset = out_offset_reg;
    assign m_session      = out_session_reg;
    assign m_last         = !out_double_reg;

endmodule
